>>> hw/rtl/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// Types and constants shared by the sync / length / checksum deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam logic [31:0] SYNC_PATTERN_RESET = 32'h1223_3445;

    localparam logic [7:0] REPLY_ACCEPT = 8'h69;
    localparam logic [7:0] REPLY_REJECT = 8'h96;
    localparam logic [7:0] REPLY_RXFAIL = 8'hbb;
    localparam logic [7:0] REPLY_GOOD   = 8'hcc;
    localparam logic [7:0] REPLY_BAD    = 8'hdd;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    localparam int SYNC_BYTES = 4;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } slcd_in_t;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       frame_good;
        logic [5:0] frame_length;
    } slcd_out_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic                  kind;
        logic [7:0]            rx_byte;
        logic [SYNC_BYTES-1:0] sync_hit;  // byte equals sync byte n (n = 0 first)
        logic                  len_ok;    // byte fits the payload store
    } slcd_cmd_t;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_COLLECT,
        PH_CHECK,
        PH_FAILED
    } slcd_phase_t;

endpackage

>>> hw/rtl/sync_length_checksum_deframer_unit.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_unit
// Serial frame receiver: sync hunt, length reply, payload capture, checksum.
//
//   channel   direction  handshake           beat
//   item      in         item_valid/stall    slcd_in_t  (kind, rx_byte)
//   result    out        result_valid/stall  slcd_out_t (reply, good, length)
//   cfg       in         cfg_valid/ready     32-bit sync pattern
//
// One beat per cycle sustained while item_stall is low; a reply is registered
// after front classify, the two-entry queue and the frame state machine.
// Reset clears the state machine, queue and result_valid; no clearing pass.
// A stalled result holds the back end; the queue absorbs up to two more beats
// before item_stall rises.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_unit
    import slcd_pkg::*;
#(
    parameter int BUFFER_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  slcd_in_t    item,
    output logic        result_valid,
    input  logic        result_stall,
    output slcd_out_t   result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    slcd_cmd_t front_cmd;
    slcd_cmd_t head_cmd;
    logic      q_full;
    logic      q_pop;
    logic      head_valid;

    assign item_stall = q_full;

    slcd_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (front_cmd)
    );

    slcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (item_valid),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    slcd_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> hw/rtl/slcd_front.sv
// ----------------------------------------------------------------------------
// slcd_front
// Holds the sync pattern register and classifies each incoming beat:
// compares the byte with all four sync bytes and with the store size.
// ----------------------------------------------------------------------------
module slcd_front
    import slcd_pkg::*;
#(
    parameter int BUFFER_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  slcd_in_t    item,
    output slcd_cmd_t   cmd
);

    logic [31:0] sync_pattern_reg;
    logic [31:0] sync_pattern_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        sync_pattern_next = sync_pattern_reg;
        if (cfg_valid)
        begin
            sync_pattern_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_pattern_reg <= SYNC_PATTERN_RESET;
        end
        else
        begin
            sync_pattern_reg <= sync_pattern_next;
        end
    end

    always_comb
    begin
        cmd.kind    = item.kind;
        cmd.rx_byte = item.rx_byte;
        for (int n = 0; n < SYNC_BYTES; n++)
        begin
            // first sync byte sits in the top byte lane
            cmd.sync_hit[n] = (item.rx_byte == sync_pattern_reg[8*(SYNC_BYTES-1-n) +: 8]);
        end
        cmd.len_ok = ({1'b0, item.rx_byte} <= 9'(BUFFER_BYTES));
    end

endmodule

>>> hw/rtl/slcd_queue.sv
// ----------------------------------------------------------------------------
// slcd_queue
// Two-entry queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module slcd_queue
    import slcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  slcd_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output slcd_cmd_t head_cmd
);

    slcd_cmd_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hw/rtl/slcd_back.sv
// ----------------------------------------------------------------------------
// slcd_back
// Frame state machine: sync hunt, length, payload collection with running
// sum, checksum. Writes the payload store and holds the reply register.
// ----------------------------------------------------------------------------
module slcd_back
    import slcd_pkg::*;
#(
    parameter int BUFFER_BYTES = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  slcd_cmd_t head_cmd,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_stall,
    output slcd_out_t result
);

    localparam int LEN_W = $clog2(BUFFER_BYTES + 1);
    localparam int IDX_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

    slcd_phase_t phase_reg;
    slcd_phase_t phase_next;
    logic [1:0]       sync_matched_reg;
    logic [1:0]       sync_matched_next;
    logic [LEN_W-1:0] expected_length_reg;
    logic [LEN_W-1:0] expected_length_next;
    logic [LEN_W-1:0] bytes_collected_reg;
    logic [LEN_W-1:0] bytes_collected_next;
    logic [7:0]       running_sum_reg;
    logic [7:0]       running_sum_next;
    logic             result_valid_reg;
    logic             result_valid_next;
    slcd_out_t        result_reg;
    slcd_out_t        result_next;

    logic [7:0]       payload_store [BUFFER_BYTES];

    logic             out_free;
    logic             is_byte;
    logic             emit;
    logic             store_wr;
    logic [LEN_W-1:0] collected_inc;
    slcd_out_t        reply;

    assign out_free      = !result_valid_reg || !result_stall;
    assign pop           = head_valid && out_free;
    assign is_byte       = (head_cmd.kind == KIND_BYTE);
    assign collected_inc = bytes_collected_reg + LEN_W'(1);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (pop)
        begin
            if (!is_byte)
            begin
                if (phase_reg == PH_COLLECT)
                begin
                    phase_next = PH_FAILED;
                end
            end
            else
            begin
                unique case (phase_reg) inside
                    PH_HUNT:
                    begin
                        if (head_cmd.sync_hit[sync_matched_reg] && sync_matched_reg == 2'd3)
                        begin
                            phase_next = PH_LENGTH;
                        end
                    end
                    PH_LENGTH:
                    begin
                        if (!head_cmd.len_ok)
                        begin
                            phase_next = PH_HUNT;
                        end
                        else if (head_cmd.rx_byte == 8'd0)
                        begin
                            phase_next = PH_CHECK;
                        end
                        else
                        begin
                            phase_next = PH_COLLECT;
                        end
                    end
                    PH_COLLECT:
                    begin
                        if (collected_inc >= expected_length_reg)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK, PH_FAILED:
                    begin
                        phase_next = PH_HUNT;
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    // datapath and reply
    always_comb
    begin
        sync_matched_next    = sync_matched_reg;
        expected_length_next = expected_length_reg;
        bytes_collected_next = bytes_collected_reg;
        running_sum_next     = running_sum_reg;
        store_wr             = 1'b0;
        emit                 = 1'b0;
        reply.reply_byte     = REPLY_BAD;
        reply.frame_good     = 1'b0;
        reply.frame_length   = 6'(expected_length_reg);
        if (pop && is_byte)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (head_cmd.sync_hit[sync_matched_reg])
                    begin
                        // wraps to zero after the fourth byte
                        sync_matched_next = sync_matched_reg + 2'd1;
                    end
                    else
                    begin
                        // mismatched byte may still open a new match
                        sync_matched_next = {1'b0, head_cmd.sync_hit[0]};
                    end
                end
                PH_LENGTH:
                begin
                    emit = 1'b1;
                    if (head_cmd.len_ok)
                    begin
                        expected_length_next = LEN_W'(head_cmd.rx_byte);
                        bytes_collected_next = '0;
                        running_sum_next     = 8'd0;
                        reply.reply_byte     = REPLY_ACCEPT;
                        reply.frame_length   = 6'(head_cmd.rx_byte);
                    end
                    else
                    begin
                        expected_length_next = '0;
                        reply.reply_byte     = REPLY_REJECT;
                        reply.frame_length   = 6'd0;
                    end
                end
                PH_COLLECT:
                begin
                    store_wr             = (bytes_collected_reg < LEN_W'(BUFFER_BYTES));
                    running_sum_next     = running_sum_reg + head_cmd.rx_byte;
                    bytes_collected_next = collected_inc;
                end
                PH_CHECK:
                begin
                    emit = 1'b1;
                    if (head_cmd.rx_byte == running_sum_reg)
                    begin
                        reply.reply_byte = REPLY_GOOD;
                        reply.frame_good = 1'b1;
                    end
                    else
                    begin
                        reply.reply_byte = REPLY_BAD;
                    end
                end
                PH_FAILED:
                begin
                    emit             = 1'b1;
                    reply.reply_byte = REPLY_RXFAIL;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // reply register: refilled as it drains
    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (pop && emit)
        begin
            result_valid_next = 1'b1;
            result_next       = reply;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HUNT;
            sync_matched_reg    <= 2'd0;
            expected_length_reg <= '0;
            bytes_collected_reg <= '0;
            running_sum_reg     <= 8'd0;
            result_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg           <= phase_next;
            sync_matched_reg    <= sync_matched_next;
            expected_length_reg <= expected_length_next;
            bytes_collected_reg <= bytes_collected_next;
            running_sum_reg     <= running_sum_next;
            result_valid_reg    <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            payload_store[bytes_collected_reg[IDX_W-1:0]] <= head_cmd.rx_byte;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
